>>> rtl/lpfa_pkg.sv
// lpfa_pkg: shared types and constants for the leader pose frame aligner
// holds the queue word layout, the register set and the cordic arctangent table
// no dependencies
package lpfa_pkg;

	localparam int TBL_LEN = 24;
	localparam int TBL_IW = 5;
	localparam logic [2:0] REG_START_X = 3'd0;
	localparam logic [2:0] REG_START_Y = 3'd1;
	localparam logic [2:0] REG_LMOUNT_X = 3'd2;
	localparam logic [2:0] REG_LMOUNT_Y = 3'd3;
	localparam logic [2:0] REG_FMOUNT_X = 3'd4;
	localparam logic [2:0] REG_FMOUNT_Y = 3'd5;
	localparam logic [31:0] START_X_RESET = 32'd19661;
	localparam logic [33:0] INV_GAIN_Q30 = 34'd652032874;
	localparam logic FUNC_FOLLOWER = 1'b1;

	// word passed from the yaw front end to the back end
	typedef struct packed {
		logic        func;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] turn;
	} item_t;

	typedef struct packed {
		logic [31:0] start_x;
		logic [31:0] start_y;
		logic [31:0] lmount_x;
		logic [31:0] lmount_y;
		logic [31:0] fmount_x;
		logic [31:0] fmount_y;
	} cfg_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [TBL_IW-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/leader_pose_frame_aligner.sv
// leader_pose_frame_aligner: aligns leader poses into the follower frame
// the yaw extraction front end feeds a two-word queue ahead of the back end; the origin latch
// pass runs three extra rotation jobs before the displacement and yaw jobs
// the back end takes a new word only when it is idle again after the last one, since it uses the single
// shared sin/cos cordic and multiplier for every job
// reset clears the back-end pose state, the queue pointers and the result valid flag; registers take their defaults
module leader_pose_frame_aligner import lpfa_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] aligned_x,
	output logic signed [31:0] aligned_y,
	output logic signed [15:0] aligned_qz,
	output logic signed [15:0] aligned_qw
);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{start_x: START_X_RESET, default: '0};
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START_X: cfg_q.start_x <= wr_data;
				REG_START_Y: cfg_q.start_y <= wr_data;
				REG_LMOUNT_X: cfg_q.lmount_x <= wr_data;
				REG_LMOUNT_Y: cfg_q.lmount_y <= wr_data;
				REG_FMOUNT_X: cfg_q.fmount_x <= wr_data;
				REG_FMOUNT_Y: cfg_q.fmount_y <= wr_data;
				default: ;
			endcase
		end
	end

	// front end: yaw extraction
	logic  f_valid;
	item_t f_item;
	logic  q_full;

	lpfa_yaw #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_yaw (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z),
		.quat_w(quat_w),
		.item_valid(f_valid),
		.item(f_item),
		.item_ready(!q_full)
	);

	// two-word queue between front and back
	item_t q_mem [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic q_push, q_pop, q_valid;

	assign q_full = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_push = f_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (q_push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, q_push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) q_mem[wr_ptr_q] <= f_item;
	end

	// back end: bookkeeping, rotations and the result word
	lpfa_back #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_item(q_mem[rd_ptr_q]),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.aligned_x(aligned_x),
		.aligned_y(aligned_y),
		.aligned_qz(aligned_qz),
		.aligned_qw(aligned_qw)
	);

endmodule

>>> rtl/lpfa_yaw.sv
// lpfa_yaw: front end, takes a pose word and reduces its quaternion to a yaw
// iterative cordic vectoring; depends on lpfa_pkg
module lpfa_yaw import lpfa_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               item_valid,
	output item_t              item,
	input  logic               item_ready
);

	localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);
	localparam logic [31:0] RND = 32'd1 << (31 - ANGLE_BITS);
	localparam logic [31:0] TURN_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_LOAD = 4'b0010,
		F_RUN  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t state_q;
	logic func_q;
	logic [31:0] px_q, py_q;
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [36:0] x_q, y_q;
	logic [31:0] z_q;
	logic zero_q;
	logic [CW-1:0] cnt_q;

	logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
	logic signed [36:0] y0, x0, dx, dy;
	logic [31:0] at, zr;

	assign p_wz = qw_q * qz_q;
	assign p_xy = qx_q * qy_q;
	assign p_yy = qy_q * qy_q;
	assign p_zz = qz_q * qz_q;
	assign y0 = (37'(p_wz) + 37'(p_xy)) <<< 1;
	assign x0 = (37'sd1 <<< 28) - ((37'(p_yy) + 37'(p_zz)) <<< 1);
	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign at = atan_turn(TBL_IW'(cnt_q));
	assign zr = z_q + RND;

	assign full = (state_q != F_IDLE);
	assign item_valid = (state_q == F_PUSH);
	assign item.func = func_q;
	assign item.px = px_q;
	assign item.py = py_q;
	assign item.turn = zero_q ? 32'd0 : (zr & TURN_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (push) state_q <= F_LOAD;
				F_LOAD: state_q <= F_RUN;
				F_RUN: if (cnt_q == LAST) state_q <= F_PUSH;
				F_PUSH: if (item_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			func_q <= func;
			px_q <= pos_x;
			py_q <= pos_y;
			qx_q <= quat_x;
			qy_q <= quat_y;
			qz_q <= quat_z;
			qw_q <= quat_w;
		end
		if (state_q == F_LOAD) begin
			zero_q <= (x0 == 37'sd0) && (y0 == 37'sd0);
			cnt_q <= '0;
			// left half plane: negate and start from a half turn
			if (x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= 32'd0;
			end
		end
		if (state_q == F_RUN) begin
			cnt_q <= cnt_q + CW'(1);
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

endmodule

>>> rtl/lpfa_back.sv
// lpfa_back: back end, pose bookkeeping, origin latch and frame rotation
// one shared sin/cos cordic and one shared 32x32 multiplier; depends on lpfa_pkg
module lpfa_back import lpfa_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] aligned_x,
	output logic signed [31:0] aligned_y,
	output logic signed [15:0] aligned_qz,
	output logic signed [15:0] aligned_qw
);

	localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

	typedef enum logic [5:0] {
		B_IDLE   = 6'b000001,
		B_DECIDE = 6'b000010,
		B_LOAD   = 6'b000100,
		B_CORDIC = 6'b001000,
		B_MUL    = 6'b010000,
		B_OUT    = 6'b100000
	} bstate_t;

	typedef enum logic [2:0] {
		J_START  = 3'd0,
		J_FMOUNT = 3'd1,
		J_LMOUNT = 3'd2,
		J_DISP   = 3'd3,
		J_YAW    = 3'd4
	} job_t;

	bstate_t state_q;
	job_t job_q;
	logic lseen_q, fseen_q, ready_q;
	logic [31:0] l_x_q, l_y_q, l_t_q, f_x_q, f_y_q, f_t_q;
	logic [31:0] lo_x_q, lo_y_q, lo_t_q, fo_x_q, fo_y_q, fo_t_q;
	logic [31:0] wo_x_q, wo_y_q, res_x_q, res_y_q, rx_q;
	logic signed [33:0] cx_q, cy_q, cz_q, c_q, s_q;
	logic flip_q;
	logic [CW-1:0] cnt_q;
	logic [2:0] ph_q;
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic out_valid_q;

	logic [31:0] ang, a_sum, vx, vy, ry, rx_new;
	logic signed [33:0] dx, dy, at, nx, ny, nz;
	logic signed [31:0] ma, mb;
	logic flip;
	logic [31:0] a_fold;
	logic signed [65:0] acc_sum;
	logic out_free;

	// angle that each job rotates by
	always_comb begin
		a_sum = fo_t_q + l_t_q - lo_t_q;
		unique case (job_q)
			J_START, J_FMOUNT: ang = fo_t_q;
			J_LMOUNT: ang = lo_t_q;
			J_DISP: ang = fo_t_q - lo_t_q;
			J_YAW: ang = {a_sum[31], a_sum[31:1]};
			default: ang = 32'd0;
		endcase
		unique case (job_q)
			J_START: begin vx = cfg.start_x; vy = cfg.start_y; end
			J_FMOUNT: begin vx = cfg.fmount_x; vy = cfg.fmount_y; end
			J_LMOUNT: begin vx = cfg.lmount_x; vy = cfg.lmount_y; end
			default: begin vx = l_x_q - lo_x_q; vy = l_y_q - lo_y_q; end
		endcase
	end

	assign flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
	assign a_fold = flip ? (ang + 32'h8000_0000) : ang;

	// one rotation-mode cordic step
	assign dx = cy_q >>> cnt_q;
	assign dy = cx_q >>> cnt_q;
	assign at = 34'(atan_turn(TBL_IW'(cnt_q)));
	always_comb begin
		if (cz_q >= 0) begin
			nx = cx_q - dx;
			ny = cy_q + dy;
			nz = cz_q - at;
		end else begin
			nx = cx_q + dx;
			ny = cy_q - dy;
			nz = cz_q + at;
		end
	end

	// products in order c*vx, s*vy, s*vx, c*vy
	always_comb begin
		ma = (ph_q == 3'd0 || ph_q == 3'd3) ? c_q[31:0] : s_q[31:0];
		mb = (ph_q == 3'd0 || ph_q == 3'd2) ? vx : vy;
		acc_sum = (ph_q == 3'd2) ? (acc_q - 66'(prod_q)) : (acc_q + 66'(prod_q));
		rx_new = acc_sum[61:30];
		ry = acc_sum[61:30];
	end

	function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
		logic signed [34:0] t;
		logic signed [18:0] r;
		t = 35'(v) + 35'sd32768;
		r = 19'(t >>> 16);
		if (r > 19'sd16384) r = 19'sd16384;
		if (r < -19'sd16384) r = -19'sd16384;
		return r[15:0];
	endfunction

	assign out_free = !out_valid_q || pop;
	assign q_pop = (state_q == B_IDLE) && q_valid;
	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			lseen_q <= 1'b0;
			fseen_q <= 1'b0;
			ready_q <= 1'b0;
			out_valid_q <= 1'b0;
			job_q <= J_START;
			l_x_q <= '0; l_y_q <= '0; l_t_q <= '0;
			f_x_q <= '0; f_y_q <= '0; f_t_q <= '0;
			lo_x_q <= '0; lo_y_q <= '0; lo_t_q <= '0;
			fo_x_q <= '0; fo_y_q <= '0; fo_t_q <= '0;
			wo_x_q <= '0; wo_y_q <= '0;
		end else begin
			if (state_q == B_OUT && out_free) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						if (q_item.func == FUNC_FOLLOWER) begin
							f_x_q <= q_item.px; f_y_q <= q_item.py; f_t_q <= q_item.turn;
							fseen_q <= 1'b1;
						end else begin
							l_x_q <= q_item.px; l_y_q <= q_item.py; l_t_q <= q_item.turn;
							lseen_q <= 1'b1;
						end
						state_q <= B_DECIDE;
					end
				end
				B_DECIDE: begin
					if (!(lseen_q && fseen_q)) begin
						state_q <= B_IDLE;
					end else if (!ready_q) begin
						lo_x_q <= l_x_q; lo_y_q <= l_y_q; lo_t_q <= l_t_q;
						fo_x_q <= f_x_q; fo_y_q <= f_y_q; fo_t_q <= f_t_q;
						ready_q <= 1'b1;
						job_q <= J_START;
						state_q <= B_LOAD;
					end else begin
						job_q <= J_DISP;
						state_q <= B_LOAD;
					end
				end
				B_LOAD: state_q <= B_CORDIC;
				B_CORDIC: begin
					if (cnt_q == LAST) state_q <= (job_q == J_YAW) ? B_OUT : B_MUL;
				end
				B_MUL: begin
					if (ph_q == 3'd4) begin
						state_q <= B_LOAD;
						unique case (job_q)
							J_START: begin
								wo_x_q <= rx_q; wo_y_q <= ry;
								job_q <= J_FMOUNT;
							end
							J_FMOUNT: begin
								wo_x_q <= wo_x_q + rx_q; wo_y_q <= wo_y_q + ry;
								job_q <= J_LMOUNT;
							end
							J_LMOUNT: begin
								wo_x_q <= wo_x_q - rx_q; wo_y_q <= wo_y_q - ry;
								job_q <= J_DISP;
							end
							default: job_q <= J_YAW;
						endcase
					end
				end
				B_OUT: begin
					if (out_free) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_LOAD) begin
			cx_q <= INV_GAIN_Q30;
			cy_q <= '0;
			cz_q <= 34'(signed'(a_fold));
			flip_q <= flip;
			cnt_q <= '0;
			ph_q <= '0;
		end
		if (state_q == B_CORDIC) begin
			cx_q <= nx;
			cy_q <= ny;
			cz_q <= nz;
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == LAST) begin
				c_q <= flip_q ? -nx : nx;
				s_q <= flip_q ? -ny : ny;
			end
		end
		if (state_q == B_MUL) begin
			ph_q <= ph_q + 3'd1;
			prod_q <= ma * mb;
			if (ph_q == 3'd1 || ph_q == 3'd3) acc_q <= 66'(prod_q) + (66'sd1 <<< 29);
			if (ph_q == 3'd2) rx_q <= rx_new;
			if (ph_q == 3'd4 && job_q == J_DISP) begin
				res_x_q <= fo_x_q + wo_x_q + rx_q;
				res_y_q <= fo_y_q + wo_y_q + ry;
			end
		end
		if (state_q == B_OUT && out_free) begin
			aligned_x <= res_x_q;
			aligned_y <= res_y_q;
			aligned_qz <= to_q14(s_q);
			aligned_qw <= to_q14(c_q);
		end
	end

endmodule
